// File: rtl/stdg_pkg.sv
// Shared types and constants of the stepper trapezoid delay generator.
// No dependencies; imported by the top level, the checkers and the testbench.
`default_nettype none

package stdg_pkg;

    // field and datapath widths
    localparam int DELAY_WIDTH   = 32;
    localparam int STEP_WIDTH    = 24;
    localparam int REG_WIDTH     = 24;
    localparam int ARITH_WIDTH   = 32;
    localparam int CFG_IDX_WIDTH = 3;
    localparam int DIV_CNT_WIDTH = $clog2(ARITH_WIDTH);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_START_DELAY = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_START_INDEX = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ACCEL_END   = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_DECEL_START = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_TOTAL_STEPS = 3'd4;

    // phase codes of a result word
    typedef enum logic [1:0] {
        PH_ACCEL = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

endpackage

`default_nettype wire

// File: rtl/stepper_trapezoid_delay_generator.sv
// Top level of the stepper trapezoid delay generator: control, ramp state and
// a bit-serial signed divider for the Austin recurrence. Depends on stdg_pkg.
//
// Usage
//   Input channel (in_valid / in_stall / restart): one word per step request.
//   restart = 1 reloads the move from the registers before the request.
//   Output channel (out_valid / out_stall / delay, phase, done_res): one word
//   per request, held in an output register until taken.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 start
//   delay, 1 start index, 2 accel end, 3 decel start, 4 total steps); the user
//   is to write only while the block is idle, which the block does not enforce.
//   Timing: a cruise step or a finished move passes S_EVAL and S_RESULT before
//   its word is loaded; a ramp step also passes S_FORM, S_ABS, S_DIV and S_FIX,
//   the restoring divider retiring one quotient bit per cycle. A new request is
//   accepted the cycle after the previous word is loaded into the output
//   register, so the block takes no request while one is in progress.
//   A stalled output word holds; the block then finishes the request in
//   progress and waits with in_stall high until the output register frees.
//   Reset clears the registers to their reset values (start delay 1, others
//   0) and the move state to step 0; no output word is pending after reset.
`default_nettype none

module stepper_trapezoid_delay_generator
    import stdg_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // configuration port
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire logic [REG_WIDTH-1:0]     cfg_data,
    // request channel
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic                     restart,
    // result channel
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic [DELAY_WIDTH-1:0]        delay,
    output logic [1:0]                    phase,
    output logic                          done_res
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_EVAL   = 7'b0000010,
        S_FORM   = 7'b0000100,
        S_ABS    = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_FIX    = 7'b0100000,
        S_RESULT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [REG_WIDTH-1:0] start_delay_reg, start_index_reg;
    logic [REG_WIDTH-1:0] accel_end_reg, decel_start_reg, total_steps_reg;

    // move state
    logic [STEP_WIDTH-1:0]  step_count_reg;
    logic [DELAY_WIDTH-1:0] delay_now_reg;
    logic [ARITH_WIDTH-1:0] ramp_index_reg, ramp_rem_reg;

    // divider operands and shift registers
    logic [ARITH_WIDTH-1:0]   nom_reg, den_reg, den_mag_reg;
    logic                     nom_neg_reg, den_neg_reg;
    logic [ARITH_WIDTH-1:0]   dq_reg, part_reg;
    logic [DIV_CNT_WIDTH-1:0] cnt_reg;

    // pending result of the request in progress
    logic [DELAY_WIDTH-1:0] res_delay_reg;
    phase_t                 res_phase_reg;
    logic                   res_done_reg;

    // output register
    logic                   out_valid_reg;
    logic [DELAY_WIDTH-1:0] out_delay_reg;
    phase_t                 out_phase_reg;
    logic                   out_done_reg;

    logic in_accept, out_free;
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // step decode for the request in progress
    logic [STEP_WIDTH-1:0] step_inc;
    logic                  at_end, cruise, mirror;
    assign step_inc = step_count_reg + 1'b1;
    assign at_end   = (step_count_reg == total_steps_reg);
    assign cruise   = (step_inc > accel_end_reg) && (step_inc <= decel_start_reg);
    assign mirror   = ({1'b0, step_inc} == ({1'b0, decel_start_reg} + 1'b1));

    // one restoring division step
    logic [ARITH_WIDTH:0] div_shift, div_diff;
    logic                 div_bit;
    assign div_shift = {part_reg, dq_reg[ARITH_WIDTH-1]};
    assign div_diff  = div_shift - {1'b0, den_mag_reg};
    assign div_bit   = !div_diff[ARITH_WIDTH];

    // recurrence result and sign correction
    logic [ARITH_WIDTH-1:0] rem_signed;
    logic                   quo_neg, corr;
    assign quo_neg    = nom_neg_reg ^ den_neg_reg;
    assign rem_signed = nom_neg_reg ? (~part_reg + 1'b1) : part_reg;
    assign corr       = den_neg_reg && !nom_neg_reg && (part_reg != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_accept) state_next = S_EVAL;
            S_EVAL:   state_next = (at_end || cruise) ? S_RESULT : S_FORM;
            S_FORM:   state_next = S_ABS;
            S_ABS:    state_next = S_DIV;
            S_DIV:    if (cnt_reg == '0) state_next = S_FIX;
            S_FIX:    state_next = S_RESULT;
            S_RESULT: if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delay_reg <= REG_WIDTH'(1);
            start_index_reg <= '0;
            accel_end_reg   <= '0;
            decel_start_reg <= '0;
            total_steps_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_DELAY: start_delay_reg <= cfg_data;
                CFG_START_INDEX: start_index_reg <= cfg_data;
                CFG_ACCEL_END:   accel_end_reg   <= cfg_data;
                CFG_DECEL_START: decel_start_reg <= cfg_data;
                CFG_TOTAL_STEPS: total_steps_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // move state: reload, step count, mirror and recurrence update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= '0;
            delay_now_reg  <= DELAY_WIDTH'(1);
            ramp_index_reg <= '0;
            ramp_rem_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept && restart)
                    begin
                        step_count_reg <= '0;
                        delay_now_reg  <= DELAY_WIDTH'(start_delay_reg);
                        ramp_index_reg <= ARITH_WIDTH'(start_index_reg);
                        ramp_rem_reg   <= '0;
                    end
                end
                S_EVAL:
                begin
                    if (!at_end)
                    begin
                        step_count_reg <= step_inc;
                        if (!cruise)
                        begin
                            // mirrored index ~n then +1 gives -n
                            if (mirror)
                            begin
                                ramp_index_reg <= ~ramp_index_reg + 1'b1;
                                ramp_rem_reg   <= ~ramp_rem_reg + 1'b1;
                            end
                            else
                                ramp_index_reg <= ramp_index_reg + 1'b1;
                        end
                    end
                end
                S_FIX:
                begin
                    delay_now_reg <= (quo_neg ? (delay_now_reg + dq_reg)
                                              : (delay_now_reg - dq_reg))
                                     + DELAY_WIDTH'(corr);
                    ramp_rem_reg  <= corr ? (part_reg + den_reg) : rem_signed;
                end
                default: ;
            endcase
        end
    end

    // divider datapath: operands, magnitudes, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_FORM:
            begin
                nom_reg <= {delay_now_reg[DELAY_WIDTH-2:0], 1'b0} + ramp_rem_reg;
                den_reg <= {ramp_index_reg[ARITH_WIDTH-3:0], 2'b01};
            end
            S_ABS:
            begin
                nom_neg_reg <= nom_reg[ARITH_WIDTH-1];
                den_neg_reg <= den_reg[ARITH_WIDTH-1];
                dq_reg      <= nom_reg[ARITH_WIDTH-1] ? (~nom_reg + 1'b1) : nom_reg;
                den_mag_reg <= den_reg[ARITH_WIDTH-1] ? (~den_reg + 1'b1) : den_reg;
                part_reg    <= '0;
                cnt_reg     <= DIV_CNT_WIDTH'(ARITH_WIDTH - 1);
            end
            S_DIV:
            begin
                part_reg <= div_bit ? div_diff[ARITH_WIDTH-1:0]
                                    : div_shift[ARITH_WIDTH-1:0];
                dq_reg   <= {dq_reg[ARITH_WIDTH-2:0], div_bit};
                cnt_reg  <= cnt_reg - 1'b1;
            end
            default: ;
        endcase
    end

    // pending result, captured before the delay moves on
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EVAL)
        begin
            if (at_end)
            begin
                res_delay_reg <= '0;
                res_phase_reg <= PH_DONE;
                res_done_reg  <= 1'b1;
            end
            else
            begin
                res_delay_reg <= delay_now_reg;
                res_done_reg  <= 1'b0;
                if (cruise)
                    res_phase_reg <= PH_CRUISE;
                else if (step_inc > decel_start_reg)
                    res_phase_reg <= PH_DECEL;
                else
                    res_phase_reg <= PH_ACCEL;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_RESULT && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RESULT && out_free)
        begin
            out_delay_reg <= res_delay_reg;
            out_phase_reg <= res_phase_reg;
            out_done_reg  <= res_done_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign delay     = out_delay_reg;
    assign phase     = out_phase_reg;
    assign done_res  = out_done_reg;

endmodule

`default_nettype wire

// File: rtl/stdg_checker.sv
// Port-level checks for the stepper trapezoid delay generator, bound to the
// top level. Depends on stdg_pkg and stepper_trapezoid_delay_generator.
`default_nettype none

module stdg_port_checks
    import stdg_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_stall,
    input wire logic                   out_valid,
    input wire logic                   out_stall,
    input wire logic [DELAY_WIDTH-1:0] delay,
    input wire logic [1:0]             phase,
    input wire logic                   done_res
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(delay) && $stable(phase)
                                   && $stable(done_res))
        else $error("stalled result word changed");

    // one request at a time: no accept right after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while another is in progress");

    // done flag matches the done phase
    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (done_res == (phase == PH_DONE)))
        else $error("done flag and phase disagree");

    // a finished move reports zero delay
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> delay == '0)
        else $error("finished move reports nonzero delay");

endmodule

bind stepper_trapezoid_delay_generator stdg_port_checks u_stdg_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .delay     (delay),
    .phase     (phase),
    .done_res  (done_res)
);

`default_nettype wire

// File: sim/stdg_checker.sv
`timescale 1ns / 100ps
// Checker for the stepper trapezoid delay generator: follows the register port
// and both channels, predicts each result word and compares it field by field.
// Depends on stdg_pkg.

module stdg_checker
    import stdg_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  wire logic [REG_WIDTH-1:0]     cfg_data,
    input  wire logic                     in_valid,
    input  wire logic                     in_stall,
    input  wire logic                     restart,
    input  wire logic                     out_valid,
    input  wire logic                     out_stall,
    input  wire logic [DELAY_WIDTH-1:0]   delay,
    input  wire logic [1:0]               phase,
    input  wire logic                     done_res,
    output int                            error_count,
    output int                            waiting_words
);

    typedef struct packed {
        logic [DELAY_WIDTH-1:0] delay;
        phase_t                 phase;
        logic                   done;
    } step_word_t;

    // shadow of the move registers
    logic [REG_WIDTH-1:0] reg_start_delay;
    logic [REG_WIDTH-1:0] reg_start_index;
    logic [REG_WIDTH-1:0] reg_accel_end;
    logic [REG_WIDTH-1:0] reg_decel_start;
    logic [REG_WIDTH-1:0] reg_total_steps;

    // move state
    logic [STEP_WIDTH-1:0]  steps_issued;
    logic [DELAY_WIDTH-1:0] ramp_delay;
    logic [ARITH_WIDTH-1:0] ramp_n;
    logic [ARITH_WIDTH-1:0] ramp_rem;

    // words predicted but not yet taken from the block
    step_word_t due_words[$];

    // start of a move from the current registers
    function automatic void reload_move();
        steps_issued = '0;
        ramp_delay   = DELAY_WIDTH'(reg_start_delay);
        ramp_n       = ARITH_WIDTH'(reg_start_index);
        ramp_rem     = '0;
    endfunction

    // serve one step request and return the delay word it yields
    function automatic step_word_t serve_request(input logic reload);
        step_word_t             w;
        logic [STEP_WIDTH:0]    mirror_at;
        logic [ARITH_WIDTH-1:0] num_w;
        logic [ARITH_WIDTH-1:0] den_w;
        longint                 num;
        longint                 den;
        longint                 quo;
        longint                 rem;
        if (reload)
            reload_move();
        if (steps_issued == STEP_WIDTH'(reg_total_steps))
        begin
            w.delay = '0;
            w.phase = PH_DONE;
            w.done  = 1'b1;
            return w;
        end
        steps_issued = steps_issued + 1'b1;
        w.delay = ramp_delay;
        w.done  = 1'b0;
        if (steps_issued > reg_accel_end && steps_issued <= reg_decel_start)
        begin
            w.phase = PH_CRUISE;
        end
        else
        begin
            // first decel step flips the ramp; all ones never matches
            mirror_at = {1'b0, reg_decel_start} + 1'b1;
            if ({1'b0, steps_issued} == mirror_at)
            begin
                ramp_n   = ~ramp_n;
                ramp_rem = '0 - ramp_rem;
            end
            // c -= (2c + r) / (4n + 1), truncating, remainder carried
            ramp_n = ramp_n + 1'b1;
            num_w  = ramp_delay + ramp_delay + ramp_rem;
            den_w  = (ramp_n << 2) + 1'b1;
            num    = $signed(num_w);
            den    = $signed(den_w);
            quo    = num / den;
            rem    = num - quo * den;
            ramp_delay = ramp_delay - quo[DELAY_WIDTH-1:0];
            // negative divisor: pull the remainder back to the same sign
            if (den < 0 && rem > 0)
            begin
                ramp_delay = ramp_delay + 1'b1;
                rem        = rem + den;
            end
            ramp_rem = rem[ARITH_WIDTH-1:0];
            w.phase  = (steps_issued > reg_decel_start) ? PH_DECEL : PH_ACCEL;
        end
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        step_word_t got;
        step_word_t want;
        if (!rst_n)
        begin
            reg_start_delay = REG_WIDTH'(1);
            reg_start_index = '0;
            reg_accel_end   = '0;
            reg_decel_start = '0;
            reg_total_steps = '0;
            reload_move();
            due_words.delete();
            waiting_words = 0;
        end
        else
        begin
            // word taken on the result channel
            if (out_valid && !out_stall)
            begin
                got.delay = delay;
                got.phase = phase_t'(phase);
                got.done  = done_res;
                if (due_words.size() == 0)
                begin
                    error_count++;
                    $display("%0t: word with none expected: delay %0d phase %0d done %0d",
                             $time, got.delay, got.phase, got.done);
                end
                else
                begin
                    want = due_words.pop_front();
                    if (got.delay !== want.delay)
                    begin
                        error_count++;
                        $display("%0t: delay expected %0d got %0d",
                                 $time, want.delay, got.delay);
                    end
                    if (got.phase !== want.phase)
                    begin
                        error_count++;
                        $display("%0t: phase expected %0d got %0d",
                                 $time, want.phase, got.phase);
                    end
                    if (got.done !== want.done)
                    begin
                        error_count++;
                        $display("%0t: done_res expected %0d got %0d",
                                 $time, want.done, got.done);
                    end
                end
            end
            // register writes; unused indexes are dropped
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_START_DELAY: reg_start_delay = cfg_data;
                    CFG_START_INDEX: reg_start_index = cfg_data;
                    CFG_ACCEL_END:   reg_accel_end   = cfg_data;
                    CFG_DECEL_START: reg_decel_start = cfg_data;
                    CFG_TOTAL_STEPS: reg_total_steps = cfg_data;
                    default: ;
                endcase
            end
            // request taken on the input channel
            if (in_valid && !in_stall)
                due_words.push_back(serve_request(restart));
            waiting_words = due_words.size();
        end
    end

endmodule

// File: sim/tb_stepper_trapezoid_delay_generator.sv
`timescale 1ns / 100ps
// Testbench top for the stepper trapezoid delay generator: drives requests,
// register writes and result stalls; stdg_checker does the prediction.
// Depends on stdg_pkg, stepper_trapezoid_delay_generator and stdg_checker.

module tb_stepper_trapezoid_delay_generator
    import stdg_pkg::*;
();

    localparam int IDLE_LIMIT  = 4000;
    localparam int ITEM_GOAL   = 1050;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 40;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
    logic [REG_WIDTH-1:0]     cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     restart   = 1'b0;
    logic                     out_stall = 1'b0;
    logic                     in_stall;
    logic                     out_valid;
    logic [DELAY_WIDTH-1:0]   delay;
    logic [1:0]               phase;
    logic                     done_res;

    int   error_count;
    int   waiting_words;
    int   gap_pct     = 0;
    int   stall_pct   = 0;
    int   sent        = 0;
    int   idle_cycles = 0;
    int   hold_left   = 0;
    logic hold_req    = 1'b0;
    logic hold_used   = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    stepper_trapezoid_delay_generator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .delay     (delay),
        .phase     (phase),
        .done_res  (done_res)
    );

    stdg_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .delay         (delay),
        .phase         (phase),
        .done_res      (done_res),
        .error_count   (error_count),
        .waiting_words (waiting_words)
    );

    // result side: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_used)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_stepper_trapezoid_delay_generator: errors");
            $finish;
        end
    end

    // offer one step request; entered and left at a falling edge
    task automatic offer_step(input logic reload);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            restart  <= 1'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        restart  <= reload;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [REG_WIDTH-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    // stop requesting and wait until every word has come out
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (waiting_words != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_move(input logic [REG_WIDTH-1:0] sd, si, ae, ds, ts,
                             input bit unused_too);
        settle();
        write_reg(CFG_START_DELAY, sd);
        write_reg(CFG_START_INDEX, si);
        write_reg(CFG_ACCEL_END, ae);
        write_reg(CFG_DECEL_START, ds);
        write_reg(CFG_TOTAL_STEPS, ts);
        if (unused_too)
            for (int k = int'(CFG_TOTAL_STEPS) + 1; k < 2 ** CFG_IDX_WIDTH; k++)
                write_reg(CFG_IDX_WIDTH'(k), REG_WIDTH'($urandom));
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [REG_WIDTH-1:0] sd, si, ae, ds, ts;
        int                   steps;
        int                   mv;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // registers at reset describe an empty move
        offer_step(1'b0);
        offer_step(1'b1);

        // full trapezoid from the slowest start, past its end
        load_move(24'hFFFFFF, 24'd0, 24'd3, 24'd5, 24'd8, 1'b1);
        offer_step(1'b1);
        repeat (8) offer_step(1'b0);

        // deceleration starting before acceleration ends, largest start index
        load_move(24'd1, 24'hFFFFFF, 24'd4, 24'd2, 24'd6, 1'b0);
        offer_step(1'b1);
        repeat (5) offer_step(1'b0);

        // deceleration start all ones: never mirrored
        load_move(24'd1000, 24'd3, 24'd1, 24'hFFFFFF, 24'd4, 1'b0);
        offer_step(1'b1);
        repeat (3) offer_step(1'b0);

        // total lowered under the step count: counting carries on
        settle();
        write_reg(CFG_TOTAL_STEPS, 24'd1);
        cfg_we <= 1'b0;
        repeat (3) offer_step(1'b0);

        // random moves, idling mode rotating per move
        mv = 0;
        while (sent < ITEM_GOAL)
        begin
            case (mv % 4)
                0: begin gap_pct = 0;  stall_pct <= 0;  end
                1: begin gap_pct = 55; stall_pct <= 0;  end
                2: begin gap_pct = 0;  stall_pct <= 55; end
                default: begin gap_pct = 22; stall_pct <= 22; end
            endcase

            ts = REG_WIDTH'($urandom_range(40, 1));
            if ($urandom_range(9) == 0)
                ts = '0;
            if (mv == 8)
                ts = 24'd30;
            ae = REG_WIDTH'($urandom_range(ts, 0));
            ds = REG_WIDTH'($urandom_range(ts, ae));
            case ($urandom_range(7))
                0: ds = '1;
                1: ds = (ae == 0) ? '0 : REG_WIDTH'($urandom_range(ae - 1, 0));
                2: ae = '1;
                default: ;
            endcase
            sd = $urandom_range(1) ? REG_WIDTH'($urandom_range(1000, 1))
                                   : REG_WIDTH'($urandom_range(24'hFFFFFF, 1));
            si = $urandom_range(1) ? REG_WIDTH'($urandom_range(100, 0))
                                   : REG_WIDTH'($urandom);
            steps = ts + $urandom_range(2, 0);
            if (mv != 8 && $urandom_range(11) == 0)
            begin
                ts    = '1;
                steps = $urandom_range(40, 5);
            end

            if (mv == 0 || $urandom_range(5) != 0)
                load_move(sd, si, ae, ds, ts, $urandom_range(3) == 0);
            // long result hold-off while requests keep coming
            if (mv == 8)
                hold_req <= 1'b1;

            offer_step(1'b1);
            for (int k = 1; k < steps; k++)
                offer_step($urandom_range(29) == 0);

            // now and then pull the total below the count mid-move
            if (ts != '1 && ts > 2 && $urandom_range(9) == 0)
            begin
                settle();
                write_reg(CFG_TOTAL_STEPS, REG_WIDTH'($urandom_range(ts - 1, 0)));
                cfg_we <= 1'b0;
                repeat (3) offer_step(1'b0);
            end
            mv++;
        end

        settle();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (error_count == 0)
            $display("tb_stepper_trapezoid_delay_generator: clean");
        else
            $display("tb_stepper_trapezoid_delay_generator: errors");
        $finish;
    end

endmodule

// File: stepper_trapezoid_delay_generator.f
rtl/stdg_pkg.sv
rtl/stepper_trapezoid_delay_generator.sv
rtl/stdg_checker.sv
sim/stdg_checker.sv
sim/tb_stepper_trapezoid_delay_generator.sv
